>>> rtl/bitmap_block_allocator_defines.svh
// Assertion macros shared by the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BBA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bitmap allocator check failed");

// Antecedent implies consequent in the same cycle.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

`endif

>>> rtl/bba_pkg.sv
// Package: sizes, command codes, transfer structs and priority encoder of the allocator.
`timescale 1ns / 1ps
package bba_pkg;
	localparam int MAP_BITS   = 4096;
	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W      = $clog2(MAP_BITS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WADDR_W    = $clog2(WORD_COUNT);

	localparam logic [2:0] OP_SET_BIT   = 3'd0;
	localparam logic [2:0] OP_TEST_BIT  = 3'd1;
	localparam logic [2:0] OP_SET_RANGE = 3'd2;
	localparam logic [2:0] OP_FIND_RUN  = 3'd3;
	localparam logic [2:0] OP_FIND_USED = 3'd4;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [IDX_W-1:0] position;
		logic [IDX_W-1:0] end_position;
		logic             status;
		logic [CNT_W-1:0] run_length;
	} cmd_t;

	typedef struct packed {
		logic             ok;
		logic             bit_value;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] last_index;
		logic [CNT_W-1:0] free_count;
	} rsp_t;

	// Index of lowest set bit; WORD_BITS when none is set.
	function automatic logic [BIT_W:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] r;
		r = (BIT_W+1)'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = (BIT_W+1)'(i);
		end
		return r;
	endfunction
endpackage

>>> rtl/bitmap_block_allocator.sv
// Bitmap block allocator: free-space bitmap in one word-wide RAM with command sequencer.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_defines.svh"
// The bitmap sits in a single-port-read, single-port-write RAM of WORD_COUNT words
// (128 x 32 at default size), one word read per cycle through a registered read port.
// Set bit and test bit read and evaluate a single word. A range command walks the
// words it covers twice, once to check and once to write. Find free run and find
// used walk forward one word per cycle from the start word and stop early on a hit.
// The next command can be taken in the cycle after the result is loaded.
// Per-word valid flags cleared at reset make the map read as all free, so no
// clearing pass is needed. One command is in flight at a time; a new command is
// taken while the previous result still waits at the output.
module bitmap_block_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bba_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bba_pkg::rsp_t rsp
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	localparam int WB  = bba_pkg::WORD_BITS;
	localparam int BW  = bba_pkg::BIT_W;
	localparam int AW  = bba_pkg::WADDR_W;
	localparam int IW  = bba_pkg::IDX_W;
	localparam int CW  = bba_pkg::CNT_W;
	localparam logic [AW-1:0] LAST_W = AW'(bba_pkg::WORD_COUNT - 1);
	localparam logic [WB-1:0] ONES   = '1;

	state_t              state_q;
	bba_pkg::cmd_t       cmd_q;
	logic                phase_q;
	logic [AW-1:0]       rd_addr_q;
	logic                rd_more_q;
	logic                ev_valid_s1;
	logic [AW-1:0]       ev_addr_s1;
	logic                rvalid_s1;
	logic [WB-1:0]       rdata_s1;
	logic [bba_pkg::WORD_COUNT-1:0] valid_q;
	logic                found_q;
	logic [IW-1:0]       first_q;
	logic [IW-1:0]       last_q;
	logic [CW-1:0]       left_q;
	logic                ok_q;
	logic                bv_q;
	logic [CW-1:0]       used_q;
	logic                rsp_valid_q;
	bba_pkg::rsp_t       rsp_q;

	logic [WB-1:0]       mem_q [bba_pkg::WORD_COUNT];

	// Address decode of the current command
	logic [AW-1:0] pos_w, end_w, stop_w;
	logic [BW-1:0] pos_b, end_b;
	logic          rd_en;
	logic          accept;

	assign pos_w  = cmd_q.position[IW-1:BW];
	assign pos_b  = cmd_q.position[BW-1:0];
	assign end_w  = cmd_q.end_position[IW-1:BW];
	assign end_b  = cmd_q.end_position[BW-1:0];
	assign accept = cmd_valid && !cmd_stall;
	assign rd_en  = (state_q == S_RUN) && rd_more_q;

	always_comb begin
		unique case (cmd_q.opcode)
			bba_pkg::OP_FIND_RUN, bba_pkg::OP_FIND_USED: stop_w = LAST_W;
			bba_pkg::OP_SET_RANGE:                       stop_w = end_w;
			default:                                     stop_w = pos_w;
		endcase
	end

	// Word evaluation
	logic [WB-1:0]   word, lo_m, range_m, bit_m, free_m, used_m;
	logic [BW-1:0]   lo_sh, hi_sh, run_b;
	logic [BW:0]     fb, ub, avail, take;
	logic [CW-1:0]   range_n;
	logic            hit, bit_now, last_word;
	logic            ev_done, ev_ok, ev_bv, ev_found, ev_restart;
	logic [IW-1:0]   ev_first, ev_last;
	logic [CW-1:0]   ev_left, used_d;
	logic            mem_we;
	logic [WB-1:0]   mem_wd;

	always_comb begin
		word      = rvalid_s1 ? rdata_s1 : '0;
		last_word = (ev_addr_s1 == LAST_W);
		lo_sh     = (ev_addr_s1 == pos_w) ? pos_b : '0;
		hi_sh     = (ev_addr_s1 == end_w) ? (BW'(WB - 1) - end_b) : '0;
		lo_m      = ONES << lo_sh;
		range_m   = lo_m & (ONES >> hi_sh);
		bit_m     = WB'(1) << pos_b;
		bit_now   = |(word & bit_m);
		range_n   = CW'(cmd_q.end_position) - CW'(cmd_q.position) + CW'(1);
		hit       = cmd_q.status ? |(word & range_m) : |(~word & range_m);
		free_m    = ~word & lo_m;
		fb        = bba_pkg::first_one(free_m);
		run_b     = found_q ? '0 : fb[BW-1:0];
		// a free run ends at the first used bit above its start
		used_m    = word & (ONES << ((cmd_q.opcode == bba_pkg::OP_FIND_RUN) ? run_b : lo_sh));
		ub        = bba_pkg::first_one(used_m);
		avail     = ub - {1'b0, run_b};
		take      = (CW'(avail) <= left_q) ? avail : left_q[BW:0];

		ev_done    = 1'b0;
		ev_ok      = 1'b0;
		ev_bv      = 1'b0;
		ev_found   = found_q;
		ev_restart = 1'b0;
		ev_first   = first_q;
		ev_last    = last_q;
		ev_left    = left_q;
		used_d     = used_q;
		mem_we     = 1'b0;
		mem_wd     = word;

		unique case (cmd_q.opcode)
			bba_pkg::OP_SET_BIT: begin
				ev_done = 1'b1;
				if (bit_now != cmd_q.status) begin
					ev_ok  = 1'b1;
					mem_we = 1'b1;
					mem_wd = cmd_q.status ? (word | bit_m) : (word & ~bit_m);
					used_d = cmd_q.status ? used_q + CW'(1) : used_q - CW'(1);
				end
			end
			bba_pkg::OP_TEST_BIT: begin
				ev_done = 1'b1;
				ev_ok   = 1'b1;
				ev_bv   = bit_now;
			end
			bba_pkg::OP_SET_RANGE: begin
				if (!phase_q) begin
					// check pass: any bit already at target fails the command
					if (hit) begin
						ev_done = 1'b1;
					end else if (ev_addr_s1 == end_w) begin
						ev_restart = 1'b1;
					end
				end else begin
					// write pass
					mem_we = 1'b1;
					mem_wd = cmd_q.status ? (word | range_m) : (word & ~range_m);
					if (ev_addr_s1 == end_w) begin
						ev_done = 1'b1;
						ev_ok   = 1'b1;
						used_d  = cmd_q.status ? used_q + range_n : used_q - range_n;
					end
				end
			end
			bba_pkg::OP_FIND_RUN: begin
				if (!found_q && fb[BW]) begin
					// still skipping used bits
					ev_done = last_word;
				end else if (found_q && avail == '0) begin
					ev_done = 1'b1;
					ev_ok   = 1'b1;
				end else begin
					ev_found = 1'b1;
					if (!found_q) ev_first = {ev_addr_s1, fb[BW-1:0]};
					ev_last = {ev_addr_s1, run_b} + IW'(take) - IW'(1);
					ev_left = left_q - CW'(take);
					ev_ok   = 1'b1;
					ev_done = (take < avail) || !ub[BW] || last_word || (ev_left == '0);
				end
			end
			bba_pkg::OP_FIND_USED: begin
				if (!ub[BW]) begin
					ev_done  = 1'b1;
					ev_ok    = 1'b1;
					ev_first = {ev_addr_s1, ub[BW-1:0]};
				end else begin
					ev_done = last_word;
				end
			end
			default: ev_done = 1'b1;
		endcase

		// write back only for a word that was just read
		mem_we = mem_we && ev_valid_s1 && (state_q == S_RUN);
	end

	// Bitmap RAM
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[ev_addr_s1] <= mem_wd;
		if (rd_en) rdata_s1 <= mem_q[rd_addr_q];
	end

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			rd_more_q   <= 1'b0;
			ev_valid_s1 <= 1'b0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			bv_q        <= 1'b0;
		end else begin
			ev_valid_s1 <= rd_en;
			if (rd_en) begin
				ev_addr_s1 <= rd_addr_q;
				rvalid_s1  <= valid_q[rd_addr_q];
				rd_addr_q  <= rd_addr_q + AW'(1);
				if (rd_addr_q == stop_w) rd_more_q <= 1'b0;
			end
			if (mem_we) valid_q[ev_addr_s1] <= 1'b1;
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= cmd;
						phase_q   <= 1'b0;
						found_q   <= 1'b0;
						first_q   <= '0;
						last_q    <= '0;
						left_q    <= cmd.run_length;
						ok_q      <= 1'b0;
						bv_q      <= 1'b0;
						rd_addr_q <= cmd.position[IW-1:BW];
						rd_more_q <= 1'b1;
						state_q   <= S_RUN;
						// commands settled without touching the map
						if (cmd.opcode == bba_pkg::OP_SET_RANGE &&
							cmd.position > cmd.end_position) begin
							ok_q      <= 1'b1;
							rd_more_q <= 1'b0;
							state_q   <= S_DONE;
						end else if ((cmd.opcode == bba_pkg::OP_FIND_RUN &&
							cmd.run_length == '0) || cmd.opcode > bba_pkg::OP_FIND_USED) begin
							rd_more_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end
				end
				S_RUN: begin
					if (ev_valid_s1) begin
						found_q <= ev_found;
						first_q <= ev_first;
						last_q  <= ev_last;
						left_q  <= ev_left;
						used_q  <= used_d;
						if (ev_restart) begin
							phase_q   <= 1'b1;
							rd_addr_q <= pos_w;
							rd_more_q <= 1'b1;
						end else if (ev_done) begin
							ok_q      <= ev_ok;
							bv_q      <= ev_bv;
							rd_more_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.ok          <= ok_q;
						rsp_q.bit_value   <= bv_q;
						rsp_q.first_index <= ok_q ? first_q : '0;
						rsp_q.last_index  <= ok_q ? last_q : '0;
						rsp_q.free_count  <= CW'(bba_pkg::MAP_BITS) - used_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`BBA_ASSERT_ALWAYS(a_used_range, used_q <= CW'(bba_pkg::MAP_BITS))
	`BBA_ASSERT_IMP(a_we_from_eval, mem_we, ev_valid_s1 && state_q == S_RUN)
	`BBA_ASSERT_IMP(a_run_order, rsp_valid_q && rsp_q.ok && rsp_q.last_index != '0,
		rsp_q.last_index >= rsp_q.first_index)
endmodule

>>> bench/tb_bitmap_block_allocator.sv
// Self-checking bench for the bitmap block allocator: queued driver, monitor, predictor.
`timescale 1ns / 1ps
module tb_bitmap_block_allocator;
	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	bba_pkg::cmd_t cmd;
	logic          rsp_valid;
	logic          rsp_stall;
	bba_pkg::rsp_t rsp;

	bitmap_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Predictor state
	logic [bba_pkg::MAP_BITS-1:0] model_map;
	int                           model_used;

	bba_pkg::cmd_t pending_cmds[$];
	bba_pkg::rsp_t expected_rsps[$];
	int   mismatches = 0;
	int   rsp_seen = 0;
	int   cmd_sent = 0;
	bit   quiet_tail = 0;
	bit   hold_sender = 0;
	int   send_gap = 0;
	int   stall_left = 0;

	// Clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Compute the result of one command and update the model map
	function automatic bba_pkg::rsp_t allocate_step(bba_pkg::cmd_t c);
		bba_pkg::rsp_t r;
		bit   hit;
		int   left;
		r = '0;
		case (c.opcode)
			bba_pkg::OP_SET_BIT: begin
				if (model_map[c.position] != c.status) begin
					model_map[c.position] = c.status;
					model_used += c.status ? 1 : -1;
					r.ok = 1'b1;
				end
			end
			bba_pkg::OP_TEST_BIT: begin
				r.ok = 1'b1;
				r.bit_value = model_map[c.position];
			end
			bba_pkg::OP_SET_RANGE: begin
				if (c.position > c.end_position) begin
					r.ok = 1'b1;
				end else begin
					r.ok = 1'b1;
					for (int i = int'(c.position); i <= int'(c.end_position); i++)
						if (model_map[i] == c.status) r.ok = 1'b0;
					if (r.ok) begin
						for (int i = int'(c.position); i <= int'(c.end_position); i++)
							model_map[i] = c.status;
						model_used += (c.status ? 1 : -1) *
							(int'(c.end_position) - int'(c.position) + 1);
					end
				end
			end
			bba_pkg::OP_FIND_RUN: begin
				hit = 0;
				left = int'(c.run_length);
				for (int i = int'(c.position); i < bba_pkg::MAP_BITS && left != 0; i++) begin
					if (!model_map[i]) begin
						if (!hit) r.first_index = i[bba_pkg::IDX_W-1:0];
						hit = 1;
						r.last_index = i[bba_pkg::IDX_W-1:0];
						left--;
					end else if (hit) begin
						break;
					end
				end
				r.ok = hit;
			end
			bba_pkg::OP_FIND_USED: begin
				for (int i = int'(c.position); i < bba_pkg::MAP_BITS; i++)
					if (model_map[i]) begin
						r.ok = 1'b1;
						r.first_index = i[bba_pkg::IDX_W-1:0];
						break;
					end
			end
			default: ;
		endcase
		r.free_count = bba_pkg::CNT_W'(bba_pkg::MAP_BITS - model_used);
		return r;
	endfunction

	// Driver: present queued commands with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_rsps.push_back(allocate_step(cmd));
				cmd_sent++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !hold_sender) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each response transfer, and drive random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected response %p", rsp);
				end else begin
					bba_pkg::rsp_t e;
					e = expected_rsps.pop_front();
					if (e !== rsp) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p got %p", e, rsp);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 19);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic bba_pkg::cmd_t make_cmd(logic [2:0] op, int p, int e, int s, int n);
		bba_pkg::cmd_t c;
		c.opcode = op;
		c.position = p[bba_pkg::IDX_W-1:0];
		c.end_position = e[bba_pkg::IDX_W-1:0];
		c.status = s[0];
		c.run_length = n[bba_pkg::CNT_W-1:0];
		return c;
	endfunction

	// Random command biased toward well-formed allocate and free traffic
	function automatic bba_pkg::cmd_t random_cmd();
		int p;
		int sel;
		int u;
		p = $urandom_range(0, bba_pkg::MAP_BITS - 1);
		sel = $urandom_range(0, 99);
		u = $urandom_range(5, 7);
		if (sel < 25)
			return make_cmd(bba_pkg::OP_SET_BIT, p, $urandom, $urandom, $urandom);
		else if (sel < 35)
			return make_cmd(bba_pkg::OP_TEST_BIT, p, $urandom, $urandom, $urandom);
		else if (sel < 60)
			return make_cmd(bba_pkg::OP_SET_RANGE, p,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, bba_pkg::MAP_BITS - 1)
				: ((p + $urandom_range(0, 40) > bba_pkg::MAP_BITS - 1) ? bba_pkg::MAP_BITS - 1
				: p + $urandom_range(0, 40)), $urandom, 0);
		else if (sel < 80)
			return make_cmd(bba_pkg::OP_FIND_RUN, p, 0, 0,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
				: $urandom_range(0, 64));
		else if (sel < 97)
			return make_cmd(bba_pkg::OP_FIND_USED, p, 0, 0, 0);
		else
			return make_cmd(u[2:0], $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Stimulus
	initial begin
		model_map = '0;
		model_used = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, failures, empty and oversize ranges
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_USED, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_RUN, 0, 0, 0, 4096));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_RUN, 5, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_BIT, 0, 0, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_BIT, 0, 0, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_BIT, 4095, 4095, 1, 8191));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_TEST_BIT, 4095, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_TEST_BIT, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_USED, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 0, 4095, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 1, 4094, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_RUN, 0, 0, 0, 8191));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 0, 4095, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 0, 4095, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 100, 50, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_BIT, 4095, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_BIT, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_SET_RANGE, 30, 33, 1, 0));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_RUN, 20, 0, 0, 100));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_RUN, 31, 0, 0, 3));
		pending_cmds.push_back(make_cmd(bba_pkg::OP_FIND_USED, 4095, 0, 0, 0));
		pending_cmds.push_back(make_cmd(3'd7, 4095, 4095, 1, 8191));
		pending_cmds.push_back(make_cmd(3'd5, 0, 0, 0, 0));
		repeat (450) pending_cmds.push_back(random_cmd());
		wait (pending_cmds.size() == 0);

		// Sender holds until the block has drained
		hold_sender = 1'b1;
		wait (expected_rsps.size() == 0 && !cmd_valid);
		hold_sender = 1'b0;
		repeat (450) pending_cmds.push_back(random_cmd());
		wait (pending_cmds.size() < 120);
		quiet_tail = 1'b1;
		wait (pending_cmds.size() == 0);
		wait (!cmd_valid && expected_rsps.size() == 0);
		repeat (200) @(posedge clk);

		$display("Ran %0d commands over bit, range and search operations; %0d responses.",
			cmd_sent, rsp_seen);
		$display("Final free count %0d, mismatches %0d.",
			bba_pkg::MAP_BITS - model_used, mismatches);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
